// File: rtl/tgad_pkg.sv
// Shared types and constants for the TGA true-color stream decoder.
package tgad_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned HdrIdxW = 5;
  localparam int unsigned CompIdxW = 2;

  localparam logic [HdrIdxW-1:0] HdrLastIdx = 5'd17;
  localparam logic [ByteW-1:0] TypeTrueColor = 8'd2;
  localparam logic [ByteW-1:0] MapNone = 8'd0;
  localparam logic [ByteW-1:0] Depth24 = 8'd24;
  localparam logic [ByteW-1:0] Depth32 = 8'd32;
  localparam logic [ByteW-1:0] AlphaOpaque = 8'hFF;

  localparam int unsigned TdataOutW = 112;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_IDSKIP = 2'd2,
    PH_PIXELS = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR_OK  = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_HDR_BAD = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NOT_TRUE  = 2'd1,
    ERR_BAD_DEPTH = 2'd2
  } err_e;

  typedef struct packed {
    kind_e            kind;
    logic [WordW-1:0] width;
    logic [WordW-1:0] height;
    logic [ByteW-1:0] bpp;
    logic [WordW-1:0] org_x;
    logic [WordW-1:0] org_y;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] alpha;
    logic             last;
    err_e             err;
  } result_t;

endpackage

// File: rtl/tga_truecolor_stream_decoder_top.sv
// Top level of the TGA true-color stream decoder with its output register.
// The decoder takes one byte of a TGA file per cycle, with tuser high on the
// first byte of each file, and emits a header transaction after the 18th
// header byte and one RGBA pixel transaction per 3 or 4 pixel bytes. Input
// ready drops only while a result sits in the output register and the
// downstream side is not taking it, so with a ready sink the block sustains
// one byte per clock cycle, and each result is registered and appears in the
// cycle after the byte that completes it.
module tga_truecolor_stream_decoder_top import tgad_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [7:0] data_byte
  input  logic [ByteW-1:0]     s_axis_tdata_i,
  // [0] file_start
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [15:0] image_width, [31:16] image_height, [39:32] bits_per_pixel,
  // [55:40] origin_x, [71:56] origin_y, [79:72] red, [87:80] green,
  // [95:88] blue, [103:96] alpha, [105:104] error_code, rest zero
  output logic [TdataOutW-1:0] m_axis_tdata_o,
  // [1:0] result_kind
  output logic [1:0]           m_axis_tuser_o,
  // last_pixel
  output logic                 m_axis_tlast_o
);

  logic    step;
  logic    res_valid;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign step = s_axis_tvalid_i && s_axis_tready_o;

  tgad_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s_axis_tdata_i),
    .start_i     (s_axis_tuser_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (step && res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {6'd0, out_q.err, out_q.alpha, out_q.blue, out_q.green,
                            out_q.red, out_q.org_y, out_q.org_x, out_q.bpp,
                            out_q.height, out_q.width};

endmodule

// File: rtl/tgad_parser.sv
// Header capture, ID skip and pixel assembly state for the TGA decoder.
module tgad_parser import tgad_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             start_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  phase_e               phase_q, phase_d;
  logic [HdrIdxW-1:0]   hidx_q, hidx_d;
  logic [ByteW-1:0]     skip_q, skip_d;
  logic [ByteW-1:0]     map_q, map_d;
  logic [ByteW-1:0]     type_q, type_d;
  logic [WordW-1:0]     ox_q, ox_d;
  logic [WordW-1:0]     oy_q, oy_d;
  logic [WordW-1:0]     wid_q, wid_d;
  logic [WordW-1:0]     hgt_q, hgt_d;
  logic [ByteW-1:0]     dep_q, dep_d;
  logic [WordW-1:0]     col_q, col_d;
  logic [WordW-1:0]     row_q, row_d;
  logic [CompIdxW-1:0]  comp_q, comp_d;
  logic [3*ByteW-1:0]   held_q, held_d;

  phase_e               phase_eff;
  logic [HdrIdxW-1:0]   hidx_eff;
  logic [3*ByteW-1:0]   held_new;
  logic [ByteW-1:0]     skip_dec;
  logic [WordW:0]       col_inc;
  logic [WordW:0]       row_inc;
  logic                 pix_done;
  err_e                 err;

  always_comb begin
    phase_d     = phase_q;
    hidx_d      = hidx_q;
    skip_d      = skip_q;
    map_d       = map_q;
    type_d      = type_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    wid_d       = wid_q;
    hgt_d       = hgt_q;
    dep_d       = dep_q;
    col_d       = col_q;
    row_d       = row_q;
    comp_d      = comp_q;
    held_d      = held_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    phase_eff   = start_i ? PH_HEADER : phase_q;
    hidx_eff    = start_i ? '0 : hidx_q;
    held_new    = held_q;
    skip_dec    = skip_q - 8'd1;
    col_inc     = {1'b0, col_q} + 17'd1;
    row_inc     = {1'b0, row_q} + 17'd1;
    pix_done    = 1'b0;
    err         = ERR_NONE;

    if (type_q != TypeTrueColor || map_q != MapNone) begin
      err = ERR_NOT_TRUE;
    end else if (dep_q != Depth24 && dep_q != Depth32) begin
      err = ERR_BAD_DEPTH;
    end

    case (comp_q)
      2'd0: held_new = {held_q[23:8], byte_i};
      2'd1: held_new = {held_q[23:16], byte_i, held_q[7:0]};
      2'd2: held_new = {byte_i, held_q[15:0]};
      default: held_new = held_q;
    endcase

    if (step_i) begin
      phase_d = phase_eff;
      hidx_d  = hidx_eff;
      case (phase_eff)
        PH_HEADER: begin
          case (hidx_eff)
            5'd0:  skip_d = byte_i;
            5'd1:  map_d = byte_i;
            5'd2:  type_d = byte_i;
            5'd8:  ox_d = {8'd0, byte_i};
            5'd9:  ox_d = {byte_i, ox_q[7:0]};
            5'd10: oy_d = {8'd0, byte_i};
            5'd11: oy_d = {byte_i, oy_q[7:0]};
            5'd12: wid_d = {8'd0, byte_i};
            5'd13: wid_d = {byte_i, wid_q[7:0]};
            5'd14: hgt_d = {8'd0, byte_i};
            5'd15: hgt_d = {byte_i, hgt_q[7:0]};
            5'd16: dep_d = byte_i;
            default: ;
          endcase
          if (hidx_eff >= HdrLastIdx) begin
            res_valid_o  = 1'b1;
            res_o.kind   = (err != ERR_NONE) ? KIND_HDR_BAD : KIND_HDR_OK;
            res_o.width  = wid_q;
            res_o.height = hgt_q;
            res_o.bpp    = dep_q;
            res_o.org_x  = ox_q;
            res_o.org_y  = oy_q;
            res_o.err    = err;
            col_d  = '0;
            row_d  = '0;
            comp_d = '0;
            held_d = '0;
            if (err != ERR_NONE) begin
              phase_d = PH_IDLE;
            end else if (wid_q == '0 || hgt_q == '0) begin
              res_o.last = 1'b1;
              phase_d    = PH_IDLE;
            end else if (skip_q != '0) begin
              phase_d = PH_IDSKIP;
            end else begin
              phase_d = PH_PIXELS;
            end
          end else begin
            hidx_d = hidx_eff + 5'd1;
          end
        end
        PH_IDSKIP: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          res_o.alpha = AlphaOpaque;
          if (comp_q != 2'd3) begin
            pix_done = (comp_q == 2'd2) && (dep_q != Depth32);
          end else begin
            res_o.alpha = byte_i;
            pix_done    = 1'b1;
          end
          if (!pix_done) begin
            held_d = held_new;
            comp_d = comp_q + 2'd1;
            res_o  = '0;
          end else begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_PIXEL;
            res_o.red   = held_new[23:16];
            res_o.green = held_new[15:8];
            res_o.blue  = held_new[7:0];
            comp_d      = '0;
            held_d      = '0;
            if (col_inc >= {1'b0, wid_q}) begin
              col_d = '0;
              if (row_inc >= {1'b0, hgt_q}) begin
                res_o.last = 1'b1;
                row_d      = '0;
                phase_d    = PH_IDLE;
              end else begin
                row_d = row_inc[WordW-1:0];
              end
            end else begin
              col_d = col_inc[WordW-1:0];
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hidx_q  <= '0;
      skip_q  <= '0;
      map_q   <= '0;
      type_q  <= '0;
      ox_q    <= '0;
      oy_q    <= '0;
      wid_q   <= '0;
      hgt_q   <= '0;
      dep_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      comp_q  <= '0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      hidx_q  <= hidx_d;
      skip_q  <= skip_d;
      map_q   <= map_d;
      type_q  <= type_d;
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      wid_q   <= wid_d;
      hgt_q   <= hgt_d;
      dep_q   <= dep_d;
      col_q   <= col_d;
      row_q   <= row_d;
      comp_q  <= comp_d;
      held_q  <= held_d;
    end
  end

endmodule
